// ===== hdl/pidm_pkg.sv =====
// ---------------------------------------------------------------------------
// PWM input duty measurement - shared package
// Widths, codes and the controller/datapath interface structs.
// ---------------------------------------------------------------------------
package pidm_pkg;

   localparam int STAMP_BITS = 16;
   localparam int DUTY_W     = 7;
   // numerator width for width*100 (100 < 2**DUTY_W)
   localparam int NUM_W      = STAMP_BITS + DUTY_W;
   localparam int DIV_STEPS  = DUTY_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);

   // opcodes
   localparam logic OP_CAPTURE = 1'b0;
   localparam logic OP_REARM   = 1'b1;

   // measurement phases
   localparam logic [1:0] PH_RISE_FIRST = 2'd0;
   localparam logic [1:0] PH_FALL       = 2'd1;
   localparam logic [1:0] PH_RISE_NEXT  = 2'd2;

   // edge polarity
   localparam logic EDGE_RISING  = 1'b0;
   localparam logic EDGE_FALLING = 1'b1;

   typedef struct packed {
      logic              accept;    // transaction taken this cycle
      logic              load_num;  // load width*100 into divider
      logic              div_en;    // one restoring step
      logic [STEP_W-1:0] div_shift; // divisor shift for this step
      logic              out_load;  // capture result into output register
      logic              out_fin;   // output comes from finished measurement
   } ctrl_cmd_type;

   typedef struct packed {
      logic completes;  // accepted capture closes a measurement
   } dp_status_type;

endpackage

// ===== hdl/pidm_ctrl.sv =====
// ---------------------------------------------------------------------------
// PWM input duty measurement - controller
// Handshake, sequencing of the duty divide and output register valid.
// ---------------------------------------------------------------------------
module pidm_ctrl
   import pidm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.accept    = req_valid && !req_stall;
      cmd.div_shift = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               if (status.completes) begin
                  state_in = ST_PREP;
               end else begin
                  cmd.out_load = 1'b1;
               end
            end
         end
         ST_PREP: begin
            cmd.load_num = 1'b1;
            cnt_in       = STEP_W'(DIV_STEPS - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_fin  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = cmd.out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hdl/pidm_dp.sv =====
// ---------------------------------------------------------------------------
// PWM input duty measurement - datapath
// Edge stamps, width/period, restoring duty divider and output register.
// ---------------------------------------------------------------------------
module pidm_dp
   import pidm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic                  req_opcode,
   input  logic [STAMP_BITS-1:0] req_stamp,
   output logic [STAMP_BITS-1:0] rsp_high_ticks,
   output logic [STAMP_BITS-1:0] rsp_period_ticks,
   output logic [DUTY_W-1:0]     rsp_duty_percent,
   output logic                  rsp_measure_done,
   output logic                  rsp_zero_period,
   output logic                  rsp_next_edge,
   output logic                  rsp_armed_flag,
   output logic                  rsp_timer_clear
);

   logic [1:0]            phase_ff, phase_in;
   logic [STAMP_BITS-1:0] first_ff, first_in;
   logic [STAMP_BITS-1:0] width_ff, width_in;
   logic [STAMP_BITS-1:0] period_ff, period_in;
   logic [DUTY_W-1:0]     duty_ff, duty_in;
   logic                  armed_ff, armed_in;
   logic [NUM_W-1:0]      rem_ff, rem_in;
   logic [DUTY_W-1:0]     quot_ff, quot_in;
   logic [NUM_W:0]        trial;
   logic [DUTY_W-1:0]     duty_fin;
   logic                  zero_p;

   logic [STAMP_BITS-1:0] o_width_ff, o_period_ff;
   logic [DUTY_W-1:0]     o_duty_ff;
   logic                  o_done_ff, o_zero_ff, o_edge_ff, o_armed_ff, o_clr_ff;

   assign status.completes = (req_opcode == OP_CAPTURE) && armed_ff
                             && (phase_ff == PH_RISE_NEXT);

   assign zero_p = (period_ff == '0);

   // saturating duty once the divider is done
   always_comb begin
      priority if (zero_p)               duty_fin = '0;
      else if (width_ff >= period_ff)    duty_fin = DUTY_FULL;
      else                               duty_fin = quot_ff;
   end

   // edge bookkeeping on an accepted transaction; duty latched when a measurement finishes
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      width_in  = width_ff;
      period_in = period_ff;
      armed_in  = armed_ff;
      duty_in   = duty_ff;
      if (cmd.accept) begin
         if (req_opcode == OP_REARM) begin
            armed_in = 1'b1;
         end else if (armed_ff) begin
            unique case (phase_ff)
               PH_RISE_FIRST: begin
                  first_in = req_stamp;
                  phase_in = PH_FALL;
               end
               PH_FALL: begin
                  width_in = req_stamp - first_ff;
                  phase_in = PH_RISE_NEXT;
               end
               PH_RISE_NEXT: begin
                  period_in = req_stamp - first_ff;
                  armed_in  = 1'b0;
                  phase_in  = PH_RISE_FIRST;
               end
               default: ; // unreachable phase: capture ignored
            endcase
         end
      end
      if (cmd.out_fin) begin
         duty_in = duty_fin;
      end
   end

   // restoring divider: width*100 / period, one quotient bit per step
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      trial   = {1'b0, rem_ff} - ((NUM_W + 1)'(period_ff) << cmd.div_shift);
      if (cmd.load_num) begin
         rem_in  = NUM_W'(width_ff) * NUM_W'(DUTY_FULL);
         quot_in = '0;
      end else if (cmd.div_en) begin
         quot_in = {quot_ff[DUTY_W-2:0], !trial[NUM_W]};
         if (!trial[NUM_W]) begin
            rem_in = trial[NUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RISE_FIRST;
         first_ff  <= '0;
         width_ff  <= '0;
         period_ff <= '0;
         duty_ff   <= '0;
         armed_ff  <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         width_ff  <= width_in;
         period_ff <= period_in;
         duty_ff   <= duty_in;
         armed_ff  <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (cmd.out_load) begin
         o_width_ff  <= width_in;
         o_period_ff <= period_in;
         o_duty_ff   <= duty_in;
         o_done_ff   <= cmd.out_fin;
         o_zero_ff   <= cmd.out_fin && zero_p;
         o_edge_ff   <= (phase_in == PH_FALL) ? EDGE_FALLING : EDGE_RISING;
         o_armed_ff  <= armed_in;
         o_clr_ff    <= cmd.out_fin;
      end
   end

   assign rsp_high_ticks   = o_width_ff;
   assign rsp_period_ticks = o_period_ff;
   assign rsp_duty_percent = o_duty_ff;
   assign rsp_measure_done = o_done_ff;
   assign rsp_zero_period  = o_zero_ff;
   assign rsp_next_edge    = o_edge_ff;
   assign rsp_armed_flag   = o_armed_ff;
   assign rsp_timer_clear  = o_clr_ff;

endmodule

// ===== hdl/pwm_input_duty_measure_top.sv =====
// ---------------------------------------------------------------------------
// PWM input duty measurement - top level
// Each request transaction is a capture edge with its timer stamp or a rearm
// command, and each yields exactly one response transaction. While armed the
// block takes a rising edge, a falling edge and the next rising edge; width
// and period are stamp differences modulo 2**16. That last edge produces the
// duty in whole percent (width*100/period, truncated, saturated at 100, 0 with
// zero_period set for a zero period), disarms the block and pulses
// timer_clear. Captures while disarmed are ignored until a rearm arrives.
// A transaction that does not finish a measurement is registered as its
// response in its accepting cycle. A finishing capture goes on to a state that
// forms width*100, the restoring divider (one quotient bit per step) and a
// state that saturates and registers the result once the response register
// is free; the request side stalls meanwhile. A new request is taken only
// when the response register is empty or is being read in that same cycle.
// ---------------------------------------------------------------------------
module pwm_input_duty_measure_top
   import pidm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [STAMP_BITS-1:0] req_stamp,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STAMP_BITS-1:0] rsp_high_ticks,
   output logic [STAMP_BITS-1:0] rsp_period_ticks,
   output logic [DUTY_W-1:0]     rsp_duty_percent,
   output logic                  rsp_measure_done,
   output logic                  rsp_zero_period,
   output logic                  rsp_next_edge,
   output logic                  rsp_armed_flag,
   output logic                  rsp_timer_clear
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing: handshake, divide steps, response valid
   pidm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // measurement state, divider and response payload
   pidm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_stamp        (req_stamp),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_measure_done (rsp_measure_done),
      .rsp_zero_period  (rsp_zero_period),
      .rsp_next_edge    (rsp_next_edge),
      .rsp_armed_flag   (rsp_armed_flag),
      .rsp_timer_clear  (rsp_timer_clear)
   );

endmodule

// ===== dv/pidm_response_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM input duty measurement - response checker
// Watches both channels. Every accepted request advances a local copy of the
// capture state and queues the response it should produce; every accepted
// response is compared field by field against the oldest queued one.
// ---------------------------------------------------------------------------
module pidm_response_checker
   import pidm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [STAMP_BITS-1:0] req_stamp,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [STAMP_BITS-1:0] rsp_high_ticks,
   input  logic [STAMP_BITS-1:0] rsp_period_ticks,
   input  logic [DUTY_W-1:0]     rsp_duty_percent,
   input  logic                  rsp_measure_done,
   input  logic                  rsp_zero_period,
   input  logic                  rsp_next_edge,
   input  logic                  rsp_armed_flag,
   input  logic                  rsp_timer_clear,
   output int                    error_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [STAMP_BITS-1:0] high_ticks;
      logic [STAMP_BITS-1:0] period_ticks;
      logic [DUTY_W-1:0]     duty_percent;
      logic                  measure_done;
      logic                  zero_period;
      logic                  next_edge;
      logic                  armed_flag;
      logic                  timer_clear;
   } duty_reply_type;

   logic [1:0]            cap_phase;
   logic [STAMP_BITS-1:0] rise_stamp;
   logic [STAMP_BITS-1:0] width_ticks;
   logic [STAMP_BITS-1:0] period_ticks;
   logic [DUTY_W-1:0]     duty_pct;
   logic                  capture_armed;

   duty_reply_type awaited_replies[$];

   initial error_count = 0;
   initial outstanding = 0;

   function automatic logic [DUTY_W-1:0] duty_from(input logic [STAMP_BITS-1:0] w,
                                                   input logic [STAMP_BITS-1:0] p);
      logic [31:0] q;
      if (p == '0) return '0;
      if (w >= p) return DUTY_FULL;
      q = (32'(w) * 32'd100) / 32'(p);
      return DUTY_W'(q);
   endfunction

   task automatic report_mismatch(input string what, input int exp_v, input int got_v);
      error_count++;
      // keep the log short if the stream gets out of step
      if (error_count <= 100)
         $display("[%0t] response mismatch: %s expected 0x%0h got 0x%0h",
                  $time, what, exp_v, got_v);
   endtask

   task automatic advance_capture(input logic op, input logic [STAMP_BITS-1:0] st);
      duty_reply_type r;
      r = '0;
      if (op == OP_REARM) begin
         capture_armed = 1'b1;
      end else if (capture_armed) begin
         case (cap_phase)
            PH_RISE_FIRST: begin
               rise_stamp = st;
               cap_phase  = PH_FALL;
            end
            PH_FALL: begin
               width_ticks = st - rise_stamp;
               cap_phase   = PH_RISE_NEXT;
            end
            PH_RISE_NEXT: begin
               capture_armed  = 1'b0;
               period_ticks   = st - rise_stamp;
               duty_pct       = duty_from(width_ticks, period_ticks);
               r.zero_period  = (period_ticks == '0);
               r.measure_done = 1'b1;
               r.timer_clear  = 1'b1;
               cap_phase      = PH_RISE_FIRST;
            end
            default: ;  // unreachable phase: capture ignored
         endcase
      end
      r.high_ticks   = width_ticks;
      r.period_ticks = period_ticks;
      r.duty_percent = duty_pct;
      r.next_edge    = (cap_phase == PH_FALL) ? EDGE_FALLING : EDGE_RISING;
      r.armed_flag   = capture_armed;
      awaited_replies.push_back(r);
   endtask

   task automatic check_reply();
      duty_reply_type e;
      if (awaited_replies.size() == 0) begin
         report_mismatch("response with nothing pending", 0, 1);
         return;
      end
      e = awaited_replies.pop_front();
      if (rsp_high_ticks !== e.high_ticks)
         report_mismatch("high_ticks", e.high_ticks, rsp_high_ticks);
      if (rsp_period_ticks !== e.period_ticks)
         report_mismatch("period_ticks", e.period_ticks, rsp_period_ticks);
      if (rsp_duty_percent !== e.duty_percent)
         report_mismatch("duty_percent", e.duty_percent, rsp_duty_percent);
      if (rsp_measure_done !== e.measure_done)
         report_mismatch("measure_done", e.measure_done, rsp_measure_done);
      if (rsp_zero_period !== e.zero_period)
         report_mismatch("zero_period", e.zero_period, rsp_zero_period);
      if (rsp_next_edge !== e.next_edge)
         report_mismatch("next_edge", e.next_edge, rsp_next_edge);
      if (rsp_armed_flag !== e.armed_flag)
         report_mismatch("armed_flag", e.armed_flag, rsp_armed_flag);
      if (rsp_timer_clear !== e.timer_clear)
         report_mismatch("timer_clear", e.timer_clear, rsp_timer_clear);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cap_phase     = PH_RISE_FIRST;
         rise_stamp    = '0;
         width_ticks   = '0;
         period_ticks  = '0;
         duty_pct      = '0;
         capture_armed = 1'b1;
         awaited_replies.delete();
      end else begin
         // responses are registered, so a transaction accepted at this edge
         // can never be the one answered at this edge
         if (rsp_valid && !rsp_stall) check_reply();
         if (req_valid && !req_stall) advance_capture(req_opcode, req_stamp);
      end
      outstanding = awaited_replies.size();
   end

endmodule

// ===== dv/tb_pwm_input_duty_measure_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM input duty measurement - testbench top
// Drives capture and rearm transactions into the block: a directed set of
// corner cases first, then randomized measurements with random idling on
// both channels, a no-idle stretch and one long response hold-off. A
// separate checker predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_pwm_input_duty_measure_top;
   import pidm_pkg::*;

   // clock and reset; reset held from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   // request channel, inputs to the block driven to known values from the start
   logic                  req_valid  = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_CAPTURE;
   logic [STAMP_BITS-1:0] req_stamp  = '0;

   // response channel
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic [STAMP_BITS-1:0] rsp_high_ticks;
   logic [STAMP_BITS-1:0] rsp_period_ticks;
   logic [DUTY_W-1:0]     rsp_duty_percent;
   logic                  rsp_measure_done;
   logic                  rsp_zero_period;
   logic                  rsp_next_edge;
   logic                  rsp_armed_flag;
   logic                  rsp_timer_clear;

   // from the checker
   int                    fail_total;
   int                    replies_pending;

   // idle rates in percent; dropped to zero for the quiet stretch
   int                    send_idle_pct = 27;
   int                    recv_idle_pct = 27;

   // a bump of hold_token asks the receiver for one long hold-off
   int                    hold_token = 0;
   int                    hold_seen  = 0;
   int                    hold_left  = 0;

   // request transactions accepted so far
   int                    counted_items = 0;

   pwm_input_duty_measure_top dut (.*);

   pidm_response_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_stamp        (req_stamp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_measure_done (rsp_measure_done),
      .rsp_zero_period  (rsp_zero_period),
      .rsp_next_edge    (rsp_next_edge),
      .rsp_armed_flag   (rsp_armed_flag),
      .rsp_timer_clear  (rsp_timer_clear),
      .error_count      (fail_total),
      .outstanding      (replies_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stall, or a long hold-off counted here when asked.
   // The sender keeps offering during the hold-off, so the response register
   // fills and the block has to stall its request side.
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // One request transaction. Idle cycles go in front of it; valid is only
   // lowered at an edge where it is not raised again, and the payload holds
   // until the transaction is taken.
   task automatic send_request(input logic op, input logic [STAMP_BITS-1:0] st);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_stamp  <= st;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counted_items++;
   endtask

   // Rising edge, falling edge, next rising edge; stamps wrap mod 2**16.
   task automatic run_measurement(input logic [STAMP_BITS-1:0] rise,
                                  input logic [STAMP_BITS-1:0] width,
                                  input logic [STAMP_BITS-1:0] period);
      send_request(OP_CAPTURE, rise);
      send_request(OP_CAPTURE, rise + width);
      send_request(OP_CAPTURE, rise + period);
   endtask

   initial begin
      logic [STAMP_BITS-1:0] rise;
      logic [STAMP_BITS-1:0] wid;
      logic [STAMP_BITS-1:0] per;
      int                    kind;
      bit                    pressure_done;

      pressure_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // zero period straight from reset, with an all-ones width
      run_measurement(16'h0000, 16'hFFFF, 16'h0000);
      // block is now disarmed: this capture is ignored
      send_request(OP_CAPTURE, 16'h1234);
      // rearm, then rearm again while already armed
      send_request(OP_REARM, 16'hFFFF);
      send_request(OP_REARM, 16'h0000);
      // wrapping stamps, and a rearm between the falling and the next rising
      // edge that must not restart the measurement: duty 50
      send_request(OP_CAPTURE, 16'hFFF0);
      send_request(OP_CAPTURE, 16'h0010);
      send_request(OP_REARM, 16'h5A5A);
      send_request(OP_CAPTURE, 16'h0030);
      // rearm while awaiting the falling edge; width above period saturates
      send_request(OP_REARM, 16'hA5A5);
      send_request(OP_CAPTURE, 16'h5555);
      send_request(OP_REARM, 16'h0001);
      send_request(OP_CAPTURE, 16'hAAAA);
      send_request(OP_CAPTURE, 16'h5556);
      // zero width over the longest period: duty 0
      send_request(OP_REARM, 16'h8000);
      run_measurement(16'd100, 16'h0000, 16'hFFFF);
      // width one tick short of the longest period: duty 99
      send_request(OP_REARM, 16'h7FFF);
      run_measurement(16'h0000, 16'hFFFE, 16'hFFFF);
      // width equal to period: full duty
      send_request(OP_REARM, 16'h0000);
      run_measurement(16'h8000, 16'h0040, 16'h0040);
      send_request(OP_REARM, 16'hFFFF);

      // ---- random part ----
      while (counted_items < 1350) begin
         // a stretch with no idling on either side
         if (counted_items >= 500 && counted_items < 700) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = 27;
            recv_idle_pct = 27;
         end
         // one long response hold-off while requests keep coming
         if (!pressure_done && counted_items >= 300) begin
            hold_token++;
            pressure_done = 1'b1;
         end

         // occasional noise: stray captures and rearms that can knock the
         // next sequence out of step
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3))
               send_request(logic'($urandom_range(1)), STAMP_BITS'($urandom_range(16'hFFFF)));

         rise = STAMP_BITS'($urandom);
         kind = $urandom_range(9);
         case (kind)
            0: begin  // zero period
               per = '0;
               wid = STAMP_BITS'($urandom);
            end
            1: begin  // width above period
               per = STAMP_BITS'($urandom_range(1, 16'hFFFE));
               wid = STAMP_BITS'($urandom_range(per + 1, 16'hFFFF));
            end
            2: begin  // width equal to period
               per = STAMP_BITS'($urandom_range(1, 16'hFFFF));
               wid = per;
            end
            3, 4, 5: begin  // short periods, fine duty steps
               per = STAMP_BITS'($urandom_range(1, 200));
               wid = STAMP_BITS'($urandom_range(0, per));
            end
            default: begin
               per = STAMP_BITS'($urandom_range(1, 16'hFFFF));
               wid = STAMP_BITS'($urandom_range(0, per));
            end
         endcase

         if ($urandom_range(9) == 0) begin
            // rearm somewhere inside the measurement
            send_request(OP_CAPTURE, rise);
            if ($urandom_range(1)) send_request(OP_REARM, STAMP_BITS'($urandom));
            send_request(OP_CAPTURE, rise + wid);
            send_request(OP_REARM, STAMP_BITS'($urandom));
            send_request(OP_CAPTURE, rise + per);
         end else begin
            run_measurement(rise, wid, per);
         end

         // sometimes poke the disarmed block before rearming it
         if ($urandom_range(7) == 0)
            send_request(OP_CAPTURE, STAMP_BITS'($urandom));
         send_request(OP_REARM, STAMP_BITS'($urandom));
      end

      // ---- drain ----
      req_valid <= 1'b0;
      @(negedge clock);
      while (replies_pending != 0) @(negedge clock);
      // let a late or extra response show up
      repeat (20) @(posedge clock);

      if (fail_total == 0 && replies_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog: far above the slowest legal run
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/pidm_pkg.sv
hdl/pidm_ctrl.sv
hdl/pidm_dp.sv
hdl/pwm_input_duty_measure_top.sv
dv/pidm_response_checker.sv
dv/tb_pwm_input_duty_measure_top.sv
